FILE: src/circular_deque_core_macros.svh
// assertion helpers for the circular deque checker
`ifndef CIRCULAR_DEQUE_CORE_MACROS_SVH
`define CIRCULAR_DEQUE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define CDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/cdq_pkg.sv
package cdq_pkg;

  // default number of entries in the circular store
  localparam int DEPTH_DEF = 8;
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 2;

  // operation codes carried in the kind field
  localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LIST       = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic                     last;
  } out_beat_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_OUT
  } cdq_state_t;

endpackage

FILE: src/cdq_store.sv
module cdq_store #(
  parameter int DEPTH  = cdq_pkg::DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [cdq_pkg::DATA_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [cdq_pkg::DATA_W-1:0]  rd_data
);
  import cdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/circular_deque_core.sv
// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   in_beat  (kind, value)
// out_      output     out_valid/out_stall out_beat (data, status, last)
//
// one item at a time; an accepted item holds the input stalled until its work is done.
// push, refused push or empty answer: decoded in S_EXEC, beat shown in S_OUT.
// pop: S_EXEC reads the store, S_READ takes the data, S_OUT shows the beat.
// unknown kinds go from S_EXEC to S_IDLE; a listing takes each entry via S_READ.
// rst_n (synchronous) empties the queue; store contents are not cleared.
// a stalled result beat holds the block; no item is taken until it goes.
module circular_deque_core #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cdq_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output cdq_pkg::out_beat_t out_beat
);
  import cdq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);
  localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

  cdq_state_t state_r, state_nxt;

  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic [IDX_W-1:0]  walk_r, walk_nxt;
  logic [OCC_W-1:0]  cnt_r, cnt_nxt;
  out_beat_t         out_r, out_nxt;

  logic [IDX_W-1:0]  step_arg, step_res;
  logic              step_dec;

  logic              mem_wr_en, mem_rd_en;
  logic [IDX_W-1:0]  mem_wr_addr, mem_rd_addr;
  logic [DATA_W-1:0] mem_rdata;

  cdq_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (value_r),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rdata)
  );

  // operand select for the shared pointer step unit
  always_comb begin
    step_arg = walk_r;
    step_dec = 1'b0;
    if (state_r == S_EXEC) begin
      case (kind_r)
        KIND_PUSH_REAR: begin
          step_arg = tail_r;
          step_dec = 1'b0;
        end
        KIND_POP_REAR: begin
          step_arg = tail_r;
          step_dec = 1'b1;
        end
        KIND_PUSH_FRONT: begin
          step_arg = head_r;
          step_dec = 1'b1;
        end
        KIND_POP_FRONT: begin
          step_arg = head_r;
          step_dec = 1'b0;
        end
        default: begin
          step_arg = walk_r;
          step_dec = 1'b0;
        end
      endcase
    end
  end

  // shared wrap-around increment / decrement
  always_comb begin
    if (step_dec) begin
      step_res = (step_arg == '0) ? IDX_MAX : step_arg - 1'b1;
    end else begin
      step_res = (step_arg == IDX_MAX) ? '0 : step_arg + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (kind_r inside {KIND_PUSH_REAR, KIND_PUSH_FRONT}) begin
          state_nxt = S_OUT;
        end else if (kind_r inside {KIND_POP_REAR, KIND_POP_FRONT, KIND_LIST}) begin
          state_nxt = (occ_r == '0) ? S_OUT : S_READ;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = (kind_r == KIND_LIST && !out_r.last) ? S_READ : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and store control per state
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    occ_nxt     = occ_r;
    kind_nxt    = kind_r;
    value_nxt   = value_r;
    walk_nxt    = walk_r;
    cnt_nxt     = cnt_r;
    out_nxt     = out_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = step_res;
    mem_rd_en   = 1'b0;
    mem_rd_addr = step_res;
    case (state_r)
      S_IDLE: begin
        kind_nxt  = in_beat.kind;
        value_nxt = in_beat.value;
      end
      S_EXEC: begin
        out_nxt.data   = '0;
        out_nxt.status = STAT_OK;
        out_nxt.last   = 1'b1;
        if (kind_r inside {KIND_PUSH_REAR, KIND_PUSH_FRONT}) begin
          // push: refuse when full, restart at entry zero when empty
          if (occ_r == OCC_FULL) begin
            out_nxt.status = STAT_FULL;
          end else begin
            occ_nxt   = occ_r + 1'b1;
            mem_wr_en = 1'b1;
            if (occ_r == '0) begin
              head_nxt    = '0;
              tail_nxt    = '0;
              mem_wr_addr = '0;
            end else if (kind_r == KIND_PUSH_REAR) begin
              tail_nxt = step_res;
            end else begin
              head_nxt = step_res;
            end
          end
        end else if (kind_r inside {KIND_POP_REAR, KIND_POP_FRONT}) begin
          // pop: read the end entry, move the pointer unless it is the last one
          if (occ_r == '0) begin
            out_nxt.status = STAT_EMPTY;
          end else begin
            mem_rd_en = 1'b1;
            occ_nxt   = occ_r - 1'b1;
            if (kind_r == KIND_POP_REAR) begin
              mem_rd_addr = tail_r;
              if (occ_r > OCC_ONE) begin
                tail_nxt = step_res;
              end
            end else begin
              mem_rd_addr = head_r;
              if (occ_r > OCC_ONE) begin
                head_nxt = step_res;
              end
            end
          end
        end else if (kind_r == KIND_LIST) begin
          // listing: start the walk at the front
          if (occ_r == '0) begin
            out_nxt.status = STAT_EMPTY;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = head_r;
            walk_nxt    = head_r;
            cnt_nxt     = '0;
          end
        end
      end
      S_READ: begin
        out_nxt.data   = signed'(mem_rdata);
        out_nxt.status = STAT_OK;
        out_nxt.last   = (kind_r != KIND_LIST) || ((cnt_r + 1'b1) == occ_r);
      end
      S_OUT: begin
        // listing: fetch the next entry once this beat is taken
        if (!out_stall && kind_r == KIND_LIST && !out_r.last) begin
          walk_nxt    = step_res;
          cnt_nxt     = cnt_r + 1'b1;
          mem_rd_en   = 1'b1;
          mem_rd_addr = step_res;
        end
      end
      default: begin
        out_nxt = out_r;
      end
    endcase
  end

  // port outputs
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    out_valid = (state_r == S_OUT);
    out_beat  = out_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    walk_r  <= walk_nxt;
    cnt_r   <= cnt_nxt;
    out_r   <= out_nxt;
  end

endmodule

FILE: src/cdq_checker.sv
`include "circular_deque_core_macros.svh"

module cdq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input cdq_pkg::in_beat_t  in_beat,
  input logic               out_valid,
  input logic               out_stall,
  input cdq_pkg::out_beat_t out_beat
);
  import cdq_pkg::*;

  // a result beat never shares a cycle with readiness for a new item
  `CDQ_ASSERT_NOW(a_ready_excl_out, !in_stall, !out_valid, "ready while result pending")

  // an accepted item closes the input until its work is done
  `CDQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "took item while busy")

  // a listing beat that is not the last keeps the block busy on the next read
  `CDQ_ASSERT_NEXT(a_list_continues, out_valid && !out_stall && !out_beat.last, !out_valid && in_stall, "listing ended early")

  // error results carry zero data and close the item
  `CDQ_ASSERT_NOW(a_error_shape, out_valid && out_beat.status != STAT_OK, out_beat.data == '0 && out_beat.last, "bad error beat")

  // a stalled beat holds
  `CDQ_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_beat), "stalled beat changed")

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_beat   (in_beat),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);

FILE: sim/circular_deque_core_test.sv
`timescale 1ns / 100ps

module circular_deque_core_test;
  import cdq_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 100;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  // kinds the block must swallow without a result
  localparam logic [KIND_W-1:0] KIND_RSVD_LO = KIND_LIST + 3'd1;
  localparam logic [KIND_W-1:0] KIND_RSVD_HI = '1;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  // deque mirror
  logic signed [DATA_W-1:0] dq_store [DEPTH];
  int dq_head;
  int dq_tail;
  int dq_count;

  out_beat_t awaited_beats[$];

  int error_count;
  int cycle_count;
  int items_sent;
  int beats_checked;
  int refused_pushes;
  int empty_answers;
  int listings;
  int burst_left;

  circular_deque_core #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // apply one operation to the mirror and queue the beats it owes
  function automatic void model_deque_op(input in_beat_t b);
    out_beat_t r;
    int idx;
    r = '0;
    r.last = 1'b1;
    r.status = STAT_OK;
    case (b.kind)
      KIND_PUSH_REAR, KIND_PUSH_FRONT: begin
        if (dq_count == DEPTH) begin
          r.status = STAT_FULL;
          refused_pushes++;
        end else begin
          if (dq_count == 0) begin
            dq_head = 0;
            dq_tail = 0;
            dq_store[0] = b.value;
          end else if (b.kind == KIND_PUSH_REAR) begin
            dq_tail = (dq_tail + 1) % DEPTH;
            dq_store[dq_tail] = b.value;
          end else begin
            dq_head = (dq_head + DEPTH - 1) % DEPTH;
            dq_store[dq_head] = b.value;
          end
          dq_count++;
        end
        awaited_beats.push_back(r);
      end
      KIND_POP_REAR, KIND_POP_FRONT: begin
        if (dq_count == 0) begin
          r.status = STAT_EMPTY;
          empty_answers++;
        end else if (b.kind == KIND_POP_REAR) begin
          r.data = dq_store[dq_tail];
          if (dq_count > 1) dq_tail = (dq_tail + DEPTH - 1) % DEPTH;
          dq_count--;
        end else begin
          r.data = dq_store[dq_head];
          if (dq_count > 1) dq_head = (dq_head + 1) % DEPTH;
          dq_count--;
        end
        awaited_beats.push_back(r);
      end
      KIND_LIST: begin
        listings++;
        if (dq_count == 0) begin
          r.status = STAT_EMPTY;
          empty_answers++;
          awaited_beats.push_back(r);
        end else begin
          idx = dq_head;
          for (int k = 0; k < dq_count; k++) begin
            r.data = dq_store[idx];
            r.last = (k == dq_count - 1);
            awaited_beats.push_back(r);
            idx = (idx + 1) % DEPTH;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s, got %h want %h", $time, what, got, want);
    error_count++;
  endtask

  // send one item, with bursts and random gaps in front of it
  task automatic send_beat(input logic [KIND_W-1:0] kind,
                           input logic signed [DATA_W-1:0] value);
    in_beat_t b;
    int gap;
    b.kind = kind;
    b.value = value;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_deque_op(b);
    items_sent++;
    burst_left--;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 15))
      0: v = {1'b1, {(DATA_W-1){1'b0}}};
      1: v = {1'b0, {(DATA_W-1){1'b1}}};
      2: v = '0;
      3: v = '1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // refusals and listing on an empty queue
  task automatic test_empty_queue();
    send_beat(KIND_LIST, $urandom);
    send_beat(KIND_POP_REAR, $urandom);
    send_beat(KIND_POP_FRONT, $urandom);
  endtask

  // both ends with extreme values, last entry popped, push into empty
  task automatic test_ends_and_extremes();
    send_beat(KIND_PUSH_REAR, {1'b0, {(DATA_W-1){1'b1}}});
    send_beat(KIND_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
    send_beat(KIND_LIST, '0);
    send_beat(KIND_POP_REAR, '1);
    send_beat(KIND_POP_FRONT, '1);
    send_beat(KIND_PUSH_FRONT, '0);
  endtask

  // fill from both ends, refused pushes, full listing
  task automatic test_full_queue();
    for (int k = 0; k < DEPTH - 1; k++)
      send_beat(k[0] ? KIND_PUSH_REAR : KIND_PUSH_FRONT, $urandom);
    send_beat(KIND_PUSH_REAR, $urandom);
    send_beat(KIND_PUSH_FRONT, $urandom);
    send_beat(KIND_LIST, $urandom);
  endtask

  // reserved kinds leave the queue alone
  task automatic test_ignored_kinds();
    for (int k = KIND_RSVD_LO; k <= KIND_RSVD_HI; k++)
      send_beat(k[KIND_W-1:0], $urandom);
  endtask

  // pops at both ends of a wrapped queue
  task automatic test_wrapped_pops();
    send_beat(KIND_POP_FRONT, $urandom);
    send_beat(KIND_POP_REAR, $urandom);
    send_beat(KIND_LIST, $urandom);
  endtask

  // fill and drain tides with random ends, values and listings
  task automatic test_random_traffic();
    bit filling;
    int done;
    int pick;
    logic [KIND_W-1:0] kind;
    logic [KIND_W-1:0] grow;
    logic [KIND_W-1:0] shrink;
    filling = 1'b1;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      if (dq_count == DEPTH && $urandom_range(0, 2) != 0) filling = 1'b0;
      else if (dq_count == 0 && $urandom_range(0, 2) != 0) filling = 1'b1;
      grow = $urandom_range(0, 1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
      shrink = $urandom_range(0, 1) ? KIND_POP_REAR : KIND_POP_FRONT;
      pick = $urandom_range(0, 99);
      if (pick < 3) kind = KIND_RSVD_LO + KIND_W'($urandom_range(0, 2));
      else if (pick < 13) kind = KIND_LIST;
      else if (pick < 80) kind = filling ? grow : shrink;
      else kind = filling ? shrink : grow;
      send_beat(kind, pick_value());
      if (kind <= KIND_LIST) done++;
    end
  endtask

  // receiver stall pattern: modes of none, light, half and heavy stalling
  int stall_mode;
  int stall_phase;
  always @(posedge clk) begin
    if (stall_phase == 0) stall_mode <= $urandom_range(0, 3);
    stall_phase <= (stall_phase + 1) % 48;
    out_stall <= (stall_mode == 0) ? 1'b0 : ($urandom_range(0, 3) < stall_mode);
  end

  // compare each result beat with the oldest owed one
  always @(posedge clk) begin : check_results
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_beats.size() == 0) begin
        report_mismatch("unexpected result beat", out_beat.data, '0);
      end else begin
        want = awaited_beats.pop_front();
        beats_checked++;
        if (out_beat.data !== want.data)
          report_mismatch("data", out_beat.data, want.data);
        if (out_beat.status !== want.status)
          report_mismatch("status", out_beat.status, want.status);
        if (out_beat.last !== want.last)
          report_mismatch("last", out_beat.last, want.last);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d beats owed", cycle_count,
               awaited_beats.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    items_sent = 0;
    refused_pushes = 0;
    empty_answers = 0;
    listings = 0;
    burst_left = 0;
    dq_head = 0;
    dq_tail = 0;
    dq_count = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_beat <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_ends_and_extremes();
    test_full_queue();
    test_ignored_kinds();
    test_wrapped_pops();
    test_random_traffic();

    // let the last beats drain
    in_valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items and %0d result beats over %0d listings",
             items_sent, beats_checked, listings);
    $display("%0d pushes refused on a full queue, %0d empty answers",
             refused_pushes, empty_answers);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
